// ===== hw/rtl/mcfb_pkg.sv =====
// Shared types, constants and helper functions for the motor command frame builder.
`default_nettype none

package mcfb_pkg;

  typedef enum logic [3:0] {
    OP_RESOLUTION = 4'd0,
    OP_SPEED_DEF  = 4'd1,
    OP_HOME       = 4'd2,
    OP_POS_MOVE   = 4'd3,
    OP_VEL_MOVE   = 4'd4,
    OP_START      = 4'd5,
    OP_POS_STOP   = 4'd6,
    OP_VEL_STOP   = 4'd7,
    OP_STATUS     = 4'd8
  } opcode_t;

  typedef enum logic [2:0] {
    REG_GEAR_A       = 3'd0,
    REG_GEAR_B       = 3'd1,
    REG_RUN_SPEED    = 3'd2,
    REG_ACCELERATION = 3'd3,
    REG_START_SPEED  = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DATA,
    BK_CRC_LO,
    BK_CRC_HI
  } bk_state_t;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [31:0] GEAR_A_RST       = 32'd1;
  localparam logic [31:0] GEAR_B_RST       = 32'd1;
  localparam logic [31:0] RUN_SPEED_RST    = 32'd8000;
  localparam logic [31:0] ACCELERATION_RST = 32'd2000;
  localparam logic [31:0] START_SPEED_RST  = 32'd0;

  localparam logic [31:0] POS_MODE_WORD = 32'h0000_0002;
  localparam logic [31:0] VEL_MODE_WORD = 32'h0000_0010;

  // first index of the data words (after header and byte count)
  localparam logic [4:0] WORD_BASE = 5'd7;

  typedef struct packed {
    opcode_t     kind;
    logic [7:0]  id;
    logic [31:0] pos;
    logic [30:0] spd;
    logic [30:0] kin;
    logic [30:0] kfi;
  } desc_t;

  typedef struct packed {
    logic [31:0] gear_a;
    logic [31:0] gear_b;
    logic [31:0] run_speed;
    logic [31:0] acceleration;
    logic [31:0] start_speed;
  } cfg_regs_t;

  // frame bytes 1..6, byte 1 in the top lane
  function automatic logic [47:0] frame_hdr(input opcode_t k);
    logic [47:0] h;
    case (k)
      OP_RESOLUTION: h = 48'h10_03_80_00_04_08;
      OP_SPEED_DEF:  h = 48'h10_02_B0_00_06_0C;
      OP_HOME:       h = 48'h06_00_7D_00_10_00;
      OP_POS_MOVE:   h = 48'h10_18_00_00_0A_14;
      OP_VEL_MOVE:   h = 48'h10_18_00_00_0A_14;
      OP_START:      h = 48'h06_00_7D_00_08_00;
      OP_POS_STOP:   h = 48'h06_00_7D_00_00_00;
      OP_VEL_STOP:   h = 48'h06_00_7D_00_20_00;
      OP_STATUS:     h = 48'h03_00_7F_00_01_00;
      default:       h = '0;
    endcase
    return h;
  endfunction

  // index of the last data byte before the CRC
  function automatic logic [4:0] last_data_idx(input opcode_t k);
    logic [4:0] n;
    case (k)
      OP_RESOLUTION: n = 5'd14;
      OP_SPEED_DEF:  n = 5'd18;
      OP_POS_MOVE:   n = 5'd26;
      OP_VEL_MOVE:   n = 5'd26;
      default:       n = 5'd5;
    endcase
    return n;
  endfunction

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mcfb_front.sv =====
// Front end: accepts commands, drops unknown opcodes, builds frame descriptors.
`default_nettype none

module mcfb_front import mcfb_pkg::*; (
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [3:0]         in_opcode,
  input  wire logic [7:0]         in_motor_id,
  input  wire logic signed [31:0] in_position,
  input  wire logic [30:0]        in_speed,
  input  wire logic [30:0]        in_start_rate,
  input  wire logic [30:0]        in_stop_decel,
  input  wire logic               q_full,
  output logic                    q_push,
  output desc_t                   q_desc
);

  logic op_known;

  always_comb begin
    case (in_opcode)
      OP_RESOLUTION, OP_SPEED_DEF, OP_HOME, OP_POS_MOVE, OP_VEL_MOVE,
      OP_START, OP_POS_STOP, OP_VEL_STOP, OP_STATUS: op_known = 1'b1;
      default:                                       op_known = 1'b0;
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && op_known;

  always_comb begin
    q_desc.kind = opcode_t'(in_opcode);
    q_desc.id   = in_motor_id;
    q_desc.pos  = (in_opcode == OP_POS_MOVE) ? $unsigned(in_position) : 32'd0;
    q_desc.spd  = in_speed;
    q_desc.kin  = in_start_rate;
    q_desc.kfi  = in_stop_decel;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mcfb_queue.sv =====
// Small descriptor queue between the front end and the byte emitter.
`default_nettype none

module mcfb_queue import mcfb_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire desc_t push_desc,
  input  wire logic  pop,
  output desc_t      pop_desc,
  output logic       full,
  output logic       empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  desc_t             mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_push;
  logic              do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_desc = mem_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mcfb_back.sv =====
// Back end: walks one frame descriptor, emits bytes and the running CRC-16.
`default_nettype none

module mcfb_back import mcfb_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cfg_regs_t cfg,
  input  wire logic      q_empty,
  input  wire desc_t     q_desc,
  output logic           q_pop,
  output logic           out_valid,
  input  wire logic      out_stall,
  output logic [7:0]     out_tx_byte,
  output logic           out_last
);

  bk_state_t   state_r, state_nxt;
  desc_t       cur_r, cur_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r, out_last_nxt;

  logic        adv;
  logic        load;
  logic [7:0]  data_byte;
  logic [47:0] hdr;
  logic [2:0]  hdr_sel;
  logic [4:0]  widx;
  logic [31:0] word;

  assign adv = !out_valid_r || !out_stall;

  // byte at idx_r of the current frame
  always_comb begin
    hdr     = frame_hdr(cur_r.kind);
    hdr_sel = 3'd6 - idx_r[2:0];
    widx    = idx_r - WORD_BASE;
    word    = '0;
    case (cur_r.kind)
      OP_RESOLUTION: begin
        case (widx[4:2])
          3'd0:    word = cfg.gear_a;
          default: word = cfg.gear_b;
        endcase
      end
      OP_SPEED_DEF: begin
        case (widx[4:2])
          3'd0:    word = cfg.run_speed;
          3'd1:    word = cfg.acceleration;
          default: word = cfg.start_speed;
        endcase
      end
      OP_POS_MOVE, OP_VEL_MOVE: begin
        case (widx[4:2])
          3'd0:    word = (cur_r.kind == OP_POS_MOVE) ? POS_MODE_WORD : VEL_MODE_WORD;
          3'd1:    word = cur_r.pos;
          3'd2:    word = {1'b0, cur_r.spd};
          3'd3:    word = {1'b0, cur_r.kin};
          default: word = {1'b0, cur_r.kfi};
        endcase
      end
      default: word = '0;
    endcase
    if (idx_r == '0) begin
      data_byte = cur_r.id;
    end else if (idx_r < WORD_BASE) begin
      data_byte = hdr[{hdr_sel, 3'b000} +: 8];
    end else begin
      data_byte = word[{2'd3 - widx[1:0], 3'b000} +: 8];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) state_nxt = BK_DATA;
      end
      BK_DATA: begin
        if (adv && idx_r == last_data_idx(cur_r.kind)) state_nxt = BK_CRC_LO;
      end
      BK_CRC_LO: begin
        if (adv) state_nxt = BK_CRC_HI;
      end
      BK_CRC_HI: begin
        if (adv) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // datapath and output stage
  always_comb begin
    q_pop        = 1'b0;
    load         = 1'b0;
    cur_nxt      = cur_r;
    idx_nxt      = idx_r;
    crc_nxt      = crc_r;
    out_byte_nxt = out_byte_r;
    out_last_nxt = out_last_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cur_nxt = q_desc;
          idx_nxt = '0;
          crc_nxt = CRC_INIT;
        end
      end
      BK_DATA: begin
        if (adv) begin
          load         = 1'b1;
          out_byte_nxt = data_byte;
          out_last_nxt = 1'b0;
          crc_nxt      = crc_byte(crc_r, data_byte);
          idx_nxt      = idx_r + 1'b1;
        end
      end
      BK_CRC_LO: begin
        if (adv) begin
          load         = 1'b1;
          out_byte_nxt = crc_r[7:0];
          out_last_nxt = 1'b0;
        end
      end
      BK_CRC_HI: begin
        if (adv) begin
          load         = 1'b1;
          out_byte_nxt = crc_r[15:8];
          out_last_nxt = 1'b1;
        end
      end
      default: ;
    endcase
    out_valid_nxt = load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    idx_r      <= idx_nxt;
    crc_r      <= crc_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_tx_byte = out_byte_r;
  assign out_last    = out_last_r;

endmodule

`default_nettype wire

// ===== hw/rtl/motor_command_frame_builder_core.sv =====
// The first frame byte passes through the queue, the emitter's idle (load) state and the output register.
// Throughput: the byte emitter puts out one byte per cycle while out_stall is low,
//   plus one load state per frame.
// Commands queue in a QUEUE_DEPTH-entry buffer while a frame is in flight.
// Reset (synchronous, active low) empties the queue, idles the emitter and
//   loads the register defaults.
`default_nettype none

module motor_command_frame_builder_core import mcfb_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [3:0]         in_opcode,
  input  wire logic [7:0]         in_motor_id,
  input  wire logic signed [31:0] in_position,
  input  wire logic [30:0]        in_speed,
  input  wire logic [30:0]        in_start_rate,
  input  wire logic [30:0]        in_stop_decel,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_tx_byte,
  output logic                    out_last,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_wdata
);

  cfg_regs_t cfg_r;
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;
  desc_t     push_desc;
  desc_t     pop_desc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gear_a       <= GEAR_A_RST;
      cfg_r.gear_b       <= GEAR_B_RST;
      cfg_r.run_speed    <= RUN_SPEED_RST;
      cfg_r.acceleration <= ACCELERATION_RST;
      cfg_r.start_speed  <= START_SPEED_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GEAR_A:       cfg_r.gear_a       <= cfg_wdata;
        REG_GEAR_B:       cfg_r.gear_b       <= cfg_wdata;
        REG_RUN_SPEED:    cfg_r.run_speed    <= cfg_wdata;
        REG_ACCELERATION: cfg_r.acceleration <= cfg_wdata;
        REG_START_SPEED:  cfg_r.start_speed  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  mcfb_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_motor_id   (in_motor_id),
    .in_position   (in_position),
    .in_speed      (in_speed),
    .in_start_rate (in_start_rate),
    .in_stop_decel (in_stop_decel),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_desc        (push_desc)
  );

  mcfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .pop       (q_pop),
    .pop_desc  (pop_desc),
    .full      (q_full),
    .empty     (q_empty)
  );

  mcfb_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_empty     (q_empty),
    .q_desc      (pop_desc),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_tx_byte (out_tx_byte),
    .out_last    (out_last)
  );

  // a frame streams without gaps until its last byte
  a_frame_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid)
    else $error("frame stream broke before last byte");

  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_empty))
    else $error("queue full and empty at once");

  // unknown opcodes are consumed without a frame
  a_unknown_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_opcode > OP_STATUS) |-> !q_push)
    else $error("unknown opcode queued");

  a_pop_only_filled: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire
